@@ design/sefu_pkg.sv @@
`default_nettype none
package sefu_pkg;

  localparam int PRIMARY_BYTES   = 256;
  localparam int SECONDARY_BYTES = 32;
  localparam int LINE_SPRITES    = 8;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;
  localparam int RES_W      = 29;

  // command codes carried in in_tuser
  typedef enum logic [1:0] {
    CMD_ADDR = 2'd0,
    CMD_DATA = 2'd1,
    CMD_READ = 2'd2,
    CMD_TICK = 2'd3
  } cmd_t;

  // where a secondary store read lands in the following cycle
  typedef enum logic [2:0] {
    DST_LATCH = 3'd0,
    DST_Y     = 3'd1,
    DST_TILE  = 3'd2,
    DST_ATTR  = 3'd3,
    DST_COL   = 3'd4
  } dst_t;

  // overflow bit positions
  localparam int OV_PRIM = 0;
  localparam int OV_SEC  = 1;
  localparam int OV_DET  = 2;
  localparam int OV_SPR  = 3;

  // zero-in-range flag positions
  localparam int Z_NEXT = 0;
  localparam int Z_CUR  = 1;

  localparam logic [7:0]  BYTE_EMPTY  = 8'hFF;
  localparam logic [7:0]  ALIGN_MASK  = 8'hFC;
  localparam logic [4:0]  HEIGHT_8    = 5'd8;
  localparam logic [12:0] PLANE_HI    = 13'h0008;

  function automatic logic [7:0] reverse8(input logic [7:0] b);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[7-i] = b[i];
    return r;
  endfunction

endpackage
`default_nettype wire

@@ design/sefu_ram.sv @@
`default_nettype none
module sefu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/sprite_evaluation_fetch_unit.sv @@
`default_nettype none
// Sprite evaluation and pattern fetch unit. One word enters per clock: an OAM
// address write, an OAM data write (address then auto-increments), an OAM data
// read, or a dot tick, and every accepted word yields exactly one result word,
// registered on the accepting edge and offered from the next cycle on; under
// back-pressure it waits in the output stage. Sustained rate is one word per
// cycle while input is not stalled; both store RAMs' read data is registered
// and folded into the consuming register in the cycle after the read
// through a pending-read bypass, so the following word already sees it. Dots
// 1-64 clear the secondary store, 65-256 run the sprite scan with the classic
// overflow behavior, 257-320 load eight sprites and request pattern addresses
// (the byte must be presented with the tick that follows), and 1-256 give a
// sprite pixel. Both stores read as 0xFF after reset through per-entry valid
// flags; no clearing pass is needed. A two-entry output stage keeps input
// accepting while one result waits; once both entries are full the input
// stalls, and it stays stalled in the cycle in which the parked word moves up.
// Configuration is taken at any time (cfg_ready is high).
module sprite_evaluation_fetch_unit
  import sefu_pkg::*;
(
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_tvalid,
  output logic                  in_tready,
  // [7:0] value, [16:8] scanline, [25:17] dot, [33:26] pattern_byte
  input  wire [IN_DATA_W-1:0]   in_tdata,
  // [1:0] command
  input  wire [1:0]             in_tuser,
  output logic                  out_tvalid,
  input  wire                   out_tready,
  // [7:0] read_data, [8] fetch_request, [21:9] pattern_address,
  // [23:22] pixel_pattern, [25:24] pixel_palette, [26] pixel_behind,
  // [27] pixel_sprite_zero, [28] overflow_flag
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire                   cfg_addr,
  input  wire [4:0]             cfg_data
);

  // input fields
  logic [7:0] f_value;
  logic [8:0] f_line;
  logic [8:0] f_dot;
  logic [7:0] f_pbyte;
  cmd_t       f_cmd;
  logic       acc;

  assign f_value = in_tdata[7:0];
  assign f_line  = in_tdata[16:8];
  assign f_dot   = in_tdata[25:17];
  assign f_pbyte = in_tdata[33:26];
  assign f_cmd   = cmd_t'(in_tuser);

  // configuration
  logic [4:0] height_r;
  logic       pts_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_8;
      pts_r    <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_addr == 1'b0) height_r <= cfg_data;
      else                  pts_r    <= cfg_data[0];
    end
  end

  // state registers
  logic [7:0]  pp_r, pp_nxt;
  logic [4:0]  sp_r, sp_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic [1:0]  copy_r, copy_nxt;
  logic [3:0]  ov_r, ov_nxt;
  logic [1:0]  z_r, z_nxt;
  logic [7:0]  fy_r, fy_nxt;
  logic [7:0]  ft_r, ft_nxt;
  logic [12:0] fa_r, fa_nxt;
  logic [7:0]  attr_r [LINE_SPRITES];
  logic [7:0]  attr_nxt [LINE_SPRITES];
  logic [7:0]  col_r [LINE_SPRITES];
  logic [7:0]  col_nxt [LINE_SPRITES];
  logic [15:0] plane_r [LINE_SPRITES];
  logic [15:0] plane_nxt [LINE_SPRITES];

  // pending reads from the stores, resolved in the following cycle
  logic       prim_pend_r, prim_pend_nxt;
  logic       sec_pend_r, sec_pend_nxt;
  dst_t       sec_dst_r, sec_dst_nxt;
  logic [2:0] sec_idx_r, sec_idx_nxt;

  // store ports
  logic                 prim_we;
  logic [7:0]           prim_q;
  logic [PRIMARY_BYTES-1:0]   prim_vld_r;
  logic                 prim_vq_r;
  logic                 sec_we;
  logic [4:0]           sec_waddr, sec_raddr;
  logic [7:0]           sec_wdata, sec_q;
  logic [SECONDARY_BYTES-1:0] sec_vld_r;
  logic                 sec_vq_r;

  sefu_ram #(.WIDTH(8), .DEPTH(PRIMARY_BYTES)) u_primary (
    .clk   (clk),
    .we    (prim_we),
    .waddr (pp_r),
    .wdata (f_value),
    .raddr (pp_r),
    .rdata (prim_q)
  );

  sefu_ram #(.WIDTH(8), .DEPTH(SECONDARY_BYTES)) u_secondary (
    .clk   (clk),
    .we    (sec_we),
    .waddr (sec_waddr),
    .wdata (sec_wdata),
    .raddr (sec_raddr),
    .rdata (sec_q)
  );

  // never-written entries read as empty
  logic [7:0] prim_eff, sec_eff;
  assign prim_eff = prim_vq_r ? prim_q : BYTE_EMPTY;
  assign sec_eff  = sec_vq_r ? sec_q : BYTE_EMPTY;

  // bypassed views of registers that may have a read in flight
  logic [7:0] latch_eff, fy_eff, ft_eff;
  logic [7:0] attr_eff [LINE_SPRITES];
  logic [7:0] col_eff [LINE_SPRITES];

  always_comb begin
    if (prim_pend_r)                                latch_eff = prim_eff;
    else if (sec_pend_r && sec_dst_r == DST_LATCH)  latch_eff = sec_eff;
    else                                            latch_eff = latch_r;
    fy_eff = (sec_pend_r && sec_dst_r == DST_Y) ? sec_eff : fy_r;
    ft_eff = (sec_pend_r && sec_dst_r == DST_TILE) ? sec_eff : ft_r;
    for (int i = 0; i < LINE_SPRITES; i++) begin
      attr_eff[i] = (sec_pend_r && sec_dst_r == DST_ATTR && sec_idx_r == 3'(i))
                    ? sec_eff : attr_r[i];
      col_eff[i]  = (sec_pend_r && sec_dst_r == DST_COL && sec_idx_r == 3'(i))
                    ? sec_eff : col_r[i];
    end
  end

  // sprite pixel: first opaque sprite in slot order
  logic [7:0] px;
  logic [1:0] pix_pat, pix_pal;
  logic       pix_behind, pix_zero;

  assign px = 8'(f_dot - 9'd1);

  always_comb begin
    logic       found;
    logic [8:0] dif;
    logic [2:0] sh;
    logic [1:0] pat;
    found      = 1'b0;
    pix_pat    = 2'd0;
    pix_pal    = 2'd0;
    pix_behind = 1'b0;
    pix_zero   = 1'b0;
    for (int i = 0; i < LINE_SPRITES; i++) begin
      dif = {1'b0, px} - {1'b0, col_eff[i]};
      sh  = 3'd7 - dif[2:0];
      pat = {plane_r[i][{1'b1, sh}], plane_r[i][{1'b0, sh}]};
      if (!found && dif[8:3] == 6'd0 && pat != 2'd0) begin
        found      = 1'b1;
        pix_pat    = pat;
        pix_pal    = attr_eff[i][1:0];
        pix_behind = attr_eff[i][5];
        pix_zero   = z_r[Z_CUR] && (i == 0);
      end
    end
  end

  // step logic
  logic [7:0]  pp_inc, pp4;
  logic [4:0]  sp_inc;
  logic [9:0]  sdiff;
  logic        hit;
  logic [5:0]  ft_off;
  logic [2:0]  phase, slot;
  logic [RES_W-1:0] res;

  assign pp_inc = pp_r + 8'd1;
  assign pp4    = (pp_r + 8'd4) & ALIGN_MASK;
  assign sp_inc = sp_r + 5'd1;
  assign sdiff  = {1'b0, f_line} - {2'b00, latch_eff};
  assign hit    = !sdiff[9] && (sdiff[8:0] < {4'd0, height_r});
  assign ft_off = 6'(f_dot - 9'd257);
  assign phase  = ft_off[2:0];
  assign slot   = ft_off[5:3];

  always_comb begin
    logic        blocked;
    logic        adv;
    logic [4:0]  sp_base;
    logic [7:0]  diff, row, pb;
    logic [12:0] addr;
    logic [7:0]  rd;
    logic        freq;
    logic [12:0] fout;
    pp_nxt        = pp_r;
    sp_nxt        = sp_r;
    latch_nxt     = latch_eff;
    copy_nxt      = copy_r;
    ov_nxt        = ov_r;
    z_nxt         = z_r;
    fy_nxt        = fy_eff;
    ft_nxt        = ft_eff;
    fa_nxt        = fa_r;
    for (int i = 0; i < LINE_SPRITES; i++) begin
      attr_nxt[i]  = attr_eff[i];
      col_nxt[i]   = col_eff[i];
      plane_nxt[i] = plane_r[i];
    end
    prim_pend_nxt = 1'b0;
    sec_pend_nxt  = 1'b0;
    sec_dst_nxt   = DST_LATCH;
    sec_idx_nxt   = slot;
    prim_we       = 1'b0;
    sec_we        = 1'b0;
    sec_waddr     = sp_r;
    sec_wdata     = BYTE_EMPTY;
    sec_raddr     = sp_r;
    blocked       = ov_r[OV_PRIM] | ov_r[OV_SEC];
    adv           = 1'b0;
    sp_base       = sp_r;
    diff          = 8'd0;
    row           = 8'd0;
    pb            = 8'd0;
    addr          = 13'd0;
    rd            = 8'd0;
    freq          = 1'b0;
    fout          = 13'd0;
    if (acc) begin
      case (f_cmd)
        CMD_ADDR: pp_nxt = f_value;
        CMD_DATA: begin
          latch_nxt = f_value;
          prim_we   = 1'b1;
          pp_nxt    = pp_inc;
        end
        CMD_READ: rd = latch_eff;
        CMD_TICK: begin
          if (f_dot >= 9'd1 && f_dot <= 9'd64) begin
            // clear pass over the secondary store
            if (f_dot == 9'd1) sp_nxt = 5'd0;
            if (!f_dot[0]) begin
              sec_we = 1'b1;
              sp_nxt = sp_inc;
            end
          end else if (f_dot >= 9'd65 && f_dot <= 9'd256) begin
            if (f_dot == 9'd65) begin
              ov_nxt[OV_PRIM] = 1'b0;
              ov_nxt[OV_SEC]  = 1'b0;
              ov_nxt[OV_SPR]  = 1'b0;
              sp_nxt          = 5'd0;
            end
            if (f_dot[0]) begin
              prim_pend_nxt = 1'b1;
            end else begin
              if (!blocked) begin
                sec_we    = 1'b1;
                sec_wdata = latch_eff;
              end else begin
                sec_pend_nxt = 1'b1;
              end
              if (copy_r != 2'd0) begin
                copy_nxt = copy_r - 2'd1;
                adv      = 1'b1;
              end else begin
                if (f_dot == 9'd66) z_nxt[Z_NEXT] = hit;
                if (hit && !blocked) begin
                  copy_nxt = 2'd3;
                  adv      = 1'b1;
                end else if (!ov_r[OV_DET]) begin
                  pp_nxt = pp4;
                  if (pp4 == 8'd0) ov_nxt[OV_PRIM] = 1'b1;
                end else if (hit && !ov_r[OV_PRIM]) begin
                  ov_nxt[OV_SPR] = 1'b1;
                  ov_nxt[OV_DET] = 1'b0;
                end else begin
                  // misaligned step of the overflow scan
                  pp_nxt = pp4 | (pp_inc & 8'h03);
                  if (pp4 == 8'd0) ov_nxt[OV_PRIM] = 1'b1;
                end
              end
              if (adv) begin
                pp_nxt      = pp_inc;
                sp_nxt      = sp_inc;
                ov_nxt[2:0] = 3'd0;
                if (pp_inc == 8'd0) ov_nxt[OV_PRIM] = 1'b1;
                if (sp_inc == 5'd0) begin
                  ov_nxt[OV_SEC] = 1'b1;
                  ov_nxt[OV_DET] = 1'b1;
                end
              end
            end
          end else if (f_dot >= 9'd257 && f_dot <= 9'd320) begin
            sp_base      = (f_dot == 9'd257) ? 5'd0 : sp_r;
            sp_nxt       = sp_base;
            z_nxt[Z_CUR] = z_r[Z_NEXT];
            case (phase)
              3'd0, 3'd1, 3'd2, 3'd3: begin
                sec_raddr    = sp_base;
                sp_nxt       = sp_base + 5'd1;
                sec_pend_nxt = 1'b1;
                case (phase)
                  3'd0:    sec_dst_nxt = DST_Y;
                  3'd1:    sec_dst_nxt = DST_TILE;
                  3'd2:    sec_dst_nxt = DST_ATTR;
                  default: sec_dst_nxt = DST_COL;
                endcase
              end
              3'd4: begin
                diff = 8'(f_line - {1'b0, fy_eff});
                row  = attr_eff[slot][7] ? ~diff : diff;
                if (height_r == HEIGHT_8)
                  addr = {pts_r, ft_eff, 1'b0, row[2:0]};
                else
                  addr = {ft_eff[0], ft_eff[7:1], row[3], 1'b0, row[2:0]};
                fa_nxt = addr;
                freq   = 1'b1;
                fout   = addr;
              end
              3'd5: begin
                pb = attr_eff[slot][6] ? reverse8(f_pbyte) : f_pbyte;
                plane_nxt[slot][7:0] = pb;
              end
              3'd6: begin
                freq = 1'b1;
                fout = fa_r | PLANE_HI;
              end
              default: begin
                pb = attr_eff[slot][6] ? reverse8(f_pbyte) : f_pbyte;
                plane_nxt[slot][15:8] = pb;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
    if (acc && f_cmd == CMD_TICK && f_dot >= 9'd1 && f_dot <= 9'd256)
      res = {ov_nxt[OV_SPR], pix_zero, pix_behind, pix_pal, pix_pat, fout, freq, rd};
    else
      res = {ov_nxt[OV_SPR], 1'b0, 1'b0, 2'd0, 2'd0, fout, freq, rd};
  end

  // output stage with skid slot
  logic             out_v_r, skid_v_r;
  logic [RES_W-1:0] out_w_r, skid_w_r;

  assign in_tready  = !skid_v_r;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-RES_W){1'b0}}, out_w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_v_r && !out_tready) begin
      // hold the waiting word, park a new one
      if (acc) begin
        skid_w_r <= res;
        skid_v_r <= 1'b1;
      end
    end else if (skid_v_r) begin
      out_w_r  <= skid_w_r;
      out_v_r  <= 1'b1;
      skid_v_r <= 1'b0;
    end else begin
      out_w_r <= res;
      out_v_r <= acc;
    end
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pp_r        <= 8'd0;
      sp_r        <= 5'd0;
      latch_r     <= 8'd0;
      copy_r      <= 2'd0;
      ov_r        <= 4'd0;
      z_r         <= 2'd0;
      fy_r        <= 8'd0;
      ft_r        <= 8'd0;
      fa_r        <= 13'd0;
      for (int i = 0; i < LINE_SPRITES; i++) begin
        attr_r[i]  <= 8'd0;
        col_r[i]   <= 8'd0;
        plane_r[i] <= 16'd0;
      end
      prim_pend_r <= 1'b0;
      sec_pend_r  <= 1'b0;
      sec_dst_r   <= DST_LATCH;
      sec_idx_r   <= 3'd0;
      prim_vld_r  <= '0;
      sec_vld_r   <= '0;
      prim_vq_r   <= 1'b0;
      sec_vq_r    <= 1'b0;
    end else begin
      pp_r        <= pp_nxt;
      sp_r        <= sp_nxt;
      latch_r     <= latch_nxt;
      copy_r      <= copy_nxt;
      ov_r        <= ov_nxt;
      z_r         <= z_nxt;
      fy_r        <= fy_nxt;
      ft_r        <= ft_nxt;
      fa_r        <= fa_nxt;
      for (int i = 0; i < LINE_SPRITES; i++) begin
        attr_r[i]  <= attr_nxt[i];
        col_r[i]   <= col_nxt[i];
        plane_r[i] <= plane_nxt[i];
      end
      prim_pend_r <= prim_pend_nxt;
      sec_pend_r  <= sec_pend_nxt;
      sec_dst_r   <= sec_dst_nxt;
      sec_idx_r   <= sec_idx_nxt;
      if (prim_we) prim_vld_r[pp_r] <= 1'b1;
      if (sec_we)  sec_vld_r[sec_waddr] <= 1'b1;
      prim_vq_r   <= prim_vld_r[pp_r];
      sec_vq_r    <= sec_vld_r[sec_raddr];
    end
  end

endmodule
`default_nettype wire
